@@ rtl/slc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Structure line classifier package
// Character codes, line kinds, class codes and the tree label lookup.
// ----------------------------------------------------------------------------
package slc_pkg;

   typedef logic [7:0] char_type;
   typedef logic [3:0] class_type;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_OPEN  = 8'h28;
   localparam char_type CH_CLOSE = 8'h29;
   localparam char_type CH_STAR  = 8'h2A;
   localparam char_type CH_DOT   = 8'h2E;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_GT    = 8'h3E;
   localparam char_type CH_AT    = 8'h40;
   localparam char_type CH_B     = 8'h42;
   localparam char_type CH_E     = 8'h45;
   localparam char_type CH_H     = 8'h48;
   localparam char_type CH_I     = 8'h49;
   localparam char_type CH_M     = 8'h4D;
   localparam char_type CH_P     = 8'h50;
   localparam char_type CH_R     = 8'h52;
   localparam char_type CH_S     = 8'h53;
   localparam char_type CH_U     = 8'h55;

   localparam logic [2:0] LEAD_OTHER = 3'd0;
   localparam logic [2:0] LEAD_DOT   = 3'd1;
   localparam logic [2:0] LEAD_OPEN  = 3'd2;
   localparam logic [2:0] LEAD_STAR  = 3'd3;
   localparam logic [2:0] LEAD_GT    = 3'd4;
   localparam logic [2:0] LEAD_AT    = 3'd5;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_DOT    = 3'd1;
   localparam logic [2:0] KIND_FULL   = 3'd2;
   localparam logic [2:0] KIND_SHAP   = 3'd3;
   localparam logic [2:0] KIND_COARSE = 3'd4;

   localparam logic [1:0] PH_ITEM  = 2'd0;
   localparam logic [1:0] PH_LABEL = 2'd1;
   localparam logic [1:0] PH_ROOT  = 2'd2;
   localparam logic [1:0] PH_CLOSE = 2'd3;

   localparam class_type CLS_SKIP        = 4'd0;
   localparam class_type CLS_DOT         = 4'd1;
   localparam class_type CLS_FULL_ROOT   = 4'd2;
   localparam class_type CLS_FULL_FREE   = 4'd3;
   localparam class_type CLS_SHAP_ROOT   = 4'd4;
   localparam class_type CLS_SHAP_FREE   = 4'd5;
   localparam class_type CLS_COARSE_ROOT = 4'd6;
   localparam class_type CLS_COARSE_FREE = 4'd7;
   localparam class_type CLS_LIST_BREAK  = 4'd8;
   localparam class_type CLS_QUIT        = 4'd9;

   // Bit 0 full alphabet, bit 1 Shapiro, bit 2 coarse.
   function automatic logic [2:0] label_set(input char_type c);
      logic [2:0] set;
      case (c)
         CH_U, CH_P:             set = 3'b001;
         CH_S, CH_E:             set = 3'b010;
         CH_H, CH_B, CH_I, CH_M: set = 3'b110;
         default:                set = 3'b000;
      endcase
      return set;
   endfunction

endpackage
`default_nettype wire

@@ rtl/slc_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Structure line classifier channels
// Valid/ready channels for characters, class codes and the mode register.
// ----------------------------------------------------------------------------
interface slc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;
   logic       input_done;
   modport source (output valid, char_code, line_end, input_done, input ready);
   modport sink   (input valid, char_code, line_end, input_done, output ready);
endinterface

interface slc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] line_class;
   modport source (output valid, line_class, input ready);
   modport sink   (input valid, line_class, output ready);
endinterface

interface slc_csr_if;
   logic valid;
   logic ready;
   logic matrix_mode;
   modport source (output valid, matrix_mode, input ready);
   modport sink   (input valid, matrix_mode, output ready);
endinterface
`default_nettype wire

@@ rtl/structure_line_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Structure line classifier
// Classifies text lines, fed one character per beat, into structure kinds.
// ----------------------------------------------------------------------------
// The req channel carries one character per beat with a line_end flag on the
// last character of a line, or an input_done beat that asks for a quit code.
// The rsp channel returns one line_class beat per line end or input_done beat.
// The csr channel writes matrix_mode, which lets '*' lines open a list; write
// it only while no line is in flight.
// Each beat is decoded against the per-line state in the same cycle it is
// accepted, and the class code appears in the result register on the next
// cycle; one character is taken every cycle unless the receiver stalls.
// When the receiver stalls, the result register holds its beat and req_ready
// drops until it is taken; the result register is the only buffer.
// Reset clears the list flag and the mode register and arms the block for the
// start of a new line; nothing is pending after reset.
// ----------------------------------------------------------------------------
module structure_line_classifier
   import slc_pkg::*;
#(
   parameter int MAX_DEPTH = 1023
) (
   input  wire         clock,
   input  wire         reset,
   slc_req_if.sink     req_bus,
   slc_rsp_if.source   rsp_bus,
   slc_csr_if.sink     csr_bus
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);
   localparam logic [DW-1:0] DEPTH_ONE   = DW'(1);

   logic            matrix_mode_ff;
   logic            list_open_ff, list_open_in;
   logic            at_start_ff, at_start_in;
   logic [2:0]      lead_ff, lead_in;
   logic            trunc_ff, trunc_in;
   logic [1:0]      guess_ff, guess_in;
   logic            saw_ff, saw_in;
   logic [DW-1:0]   bdepth_ff, bdepth_in;
   logic            bgood_ff, bgood_in;
   logic [DW-1:0]   tdepth_ff, tdepth_in;
   logic [1:0]      phase_ff, phase_in;
   logic [2:0]      tgood_ff, tgood_in;
   char_type        prev_ff, prev_in;
   char_type        prev2_ff, prev2_in;
   logic            rsp_valid_ff, rsp_valid_in;
   class_type       class_ff, class_in;

   logic            fire;
   logic            first;
   char_type        c;
   logic [2:0]      set;
   logic [2:0]      kind;
   logic            brackets;
   logic            rooted;
   logic [2:0]      tree_ok;

   assign c            = req_bus.char_code;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire         = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.line_class = class_ff;
   assign set          = label_set(c);

   always_comb begin
      // Per-line state reads as cleared on the first character of a line.
      first     = at_start_ff;
      lead_in   = first ? LEAD_OTHER : lead_ff;
      trunc_in  = first ? 1'b0 : trunc_ff;
      guess_in  = first ? 2'd0 : guess_ff;
      saw_in    = first ? 1'b0 : saw_ff;
      bdepth_in = first ? '0 : bdepth_ff;
      bgood_in  = first ? 1'b1 : bgood_ff;
      tdepth_in = first ? '0 : tdepth_ff;
      phase_in  = first ? PH_ITEM : phase_ff;
      tgood_in  = first ? 3'b111 : tgood_ff;
      prev_in   = first ? CH_NUL : prev_ff;
      prev2_in  = first ? CH_NUL : prev2_ff;
      list_open_in = list_open_ff;
      at_start_in  = req_bus.line_end;
      kind      = KIND_NONE;
      class_in  = CLS_SKIP;

      if (first) begin
         case (c)
            CH_DOT:  lead_in = LEAD_DOT;
            CH_OPEN: lead_in = LEAD_OPEN;
            CH_STAR: lead_in = LEAD_STAR;
            CH_GT:   lead_in = LEAD_GT;
            CH_AT:   lead_in = LEAD_AT;
            default: lead_in = LEAD_OTHER;
         endcase
      end

      if (!trunc_in && (lead_in == LEAD_DOT || lead_in == LEAD_OPEN)) begin
         if (c == CH_SPACE || c == CH_NUL) begin
            trunc_in = 1'b1;
         end else begin
            if (c == CH_OPEN) begin
               if (bdepth_in >= DEPTH_LIMIT) bgood_in = 1'b0;
               else bdepth_in = bdepth_in + DEPTH_ONE;
            end else if (c == CH_CLOSE) begin
               if (bdepth_in == '0) bgood_in = 1'b0;
               else bdepth_in = bdepth_in - DEPTH_ONE;
            end else if (c != CH_DOT) begin
               bgood_in = 1'b0;
            end

            if (phase_in == PH_CLOSE && prev2_in == CH_R) begin
               tgood_in = 3'b000;
            end else if (phase_in == PH_LABEL) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  phase_in = PH_LABEL;
               end else if (c == CH_CLOSE) begin
                  if (tdepth_in == '0) tgood_in = 3'b000;
                  else tdepth_in = tdepth_in - DEPTH_ONE;
                  phase_in = PH_CLOSE;
               end else begin
                  tgood_in = 3'b000;
               end
            end else if (phase_in == PH_ROOT) begin
               if (c == CH_CLOSE) begin
                  if (tdepth_in == '0) tgood_in = 3'b000;
                  else tdepth_in = tdepth_in - DEPTH_ONE;
                  phase_in = PH_CLOSE;
               end else begin
                  tgood_in = 3'b000;
               end
            end else if (c == CH_OPEN) begin
               if (tdepth_in >= DEPTH_LIMIT) tgood_in = 3'b000;
               else tdepth_in = tdepth_in + DEPTH_ONE;
               phase_in = PH_ITEM;
            end else if (set != 3'b000) begin
               tgood_in = tgood_in & set;
               phase_in = PH_LABEL;
            end else if (c == CH_R) begin
               phase_in = PH_ROOT;
            end else if (c == CH_CLOSE && phase_in == PH_ITEM) begin
               if (tdepth_in == '0) tgood_in = 3'b000;
               else tdepth_in = tdepth_in - DEPTH_ONE;
               phase_in = PH_CLOSE;
            end else begin
               tgood_in = 3'b000;
            end

            if (!first && guess_in == KIND_NONE[1:0]) begin
               if (c == CH_DOT) begin
                  guess_in = KIND_DOT[1:0];
               end else if (c == CH_U || c == CH_P) begin
                  guess_in = KIND_FULL[1:0];
                  saw_in   = 1'b1;
               end else if (c == CH_S) begin
                  guess_in = KIND_SHAP[1:0];
                  saw_in   = 1'b1;
               end else if (c != CH_OPEN && c != CH_CLOSE) begin
                  saw_in = 1'b1;
               end
            end

            prev2_in = prev_in;
            prev_in  = c;
         end
      end

      brackets = bgood_in && bdepth_in == '0;
      rooted   = prev2_in == CH_R;
      tree_ok  = (phase_in == PH_CLOSE && tdepth_in == '0) ? tgood_in : 3'b000;
      if (guess_in != KIND_NONE[1:0]) kind = {1'b0, guess_in};
      else if (saw_in) kind = KIND_COARSE;
      else kind = KIND_DOT;

      case (lead_in)
         LEAD_DOT: begin
            class_in = brackets ? CLS_DOT : CLS_SKIP;
         end
         LEAD_OPEN: begin
            case (kind)
               KIND_DOT:
                  class_in = brackets ? CLS_DOT : CLS_SKIP;
               KIND_FULL:
                  class_in = !tree_ok[0] ? CLS_SKIP :
                             rooted ? CLS_FULL_ROOT : CLS_FULL_FREE;
               KIND_SHAP:
                  class_in = !tree_ok[1] ? CLS_SKIP :
                             rooted ? CLS_SHAP_ROOT : CLS_SHAP_FREE;
               default:
                  class_in = !tree_ok[2] ? CLS_SKIP :
                             rooted ? CLS_COARSE_ROOT : CLS_COARSE_FREE;
            endcase
         end
         LEAD_STAR: begin
            if (!list_open_ff) begin
               list_open_in = matrix_mode_ff;
               class_in     = CLS_SKIP;
            end else begin
               class_in = CLS_LIST_BREAK;
            end
         end
         LEAD_AT: begin
            class_in = CLS_QUIT;
         end
         default: begin
            class_in = CLS_SKIP;
         end
      endcase

      if (!req_bus.line_end) list_open_in = list_open_ff;

      if (req_bus.input_done) begin
         class_in     = CLS_QUIT;
         at_start_in  = 1'b1;
         list_open_in = list_open_ff;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (fire && (req_bus.line_end || req_bus.input_done)) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_mode_ff <= 1'b0;
         list_open_ff   <= 1'b0;
         at_start_ff    <= 1'b1;
         lead_ff        <= LEAD_OTHER;
         trunc_ff       <= 1'b0;
         guess_ff       <= 2'd0;
         saw_ff         <= 1'b0;
         bdepth_ff      <= '0;
         bgood_ff       <= 1'b1;
         tdepth_ff      <= '0;
         phase_ff       <= PH_ITEM;
         tgood_ff       <= 3'b111;
         prev_ff        <= CH_NUL;
         prev2_ff       <= CH_NUL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid) matrix_mode_ff <= csr_bus.matrix_mode;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            list_open_ff <= list_open_in;
            at_start_ff  <= at_start_in;
            lead_ff      <= lead_in;
            trunc_ff     <= trunc_in;
            guess_ff     <= guess_in;
            saw_ff       <= saw_in;
            bdepth_ff    <= bdepth_in;
            bgood_ff     <= bgood_in;
            tdepth_ff    <= tdepth_in;
            phase_ff     <= phase_in;
            tgood_ff     <= tgood_in;
            prev_ff      <= prev_in;
            prev2_ff     <= prev2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (req_bus.line_end || req_bus.input_done)) class_ff <= class_in;
   end

endmodule
`default_nettype wire

@@ rtl/slc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Structure line classifier checker
// Port-level assertions on result timing, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker
   import slc_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_line_end,
   input wire       req_input_done,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [3:0] rsp_line_class
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_class))
      else $error("result beat dropped or changed while stalled");

   a_quit: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_input_done |=> rsp_valid && rsp_line_class == CLS_QUIT)
      else $error("input_done beat did not give a quit code");

   a_line_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_line_end |=> rsp_valid)
      else $error("line end gave no result beat");

   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_line_end && !req_input_done |=> !rsp_valid)
      else $error("mid-line character gave a result beat");

endmodule

bind structure_line_classifier slc_checker u_slc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_line_end   (req_bus.line_end),
   .req_input_done (req_bus.input_done),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_line_class (rsp_bus.line_class)
);
`default_nettype wire

@@ dv/tb_structure_line_classifier.sv @@
// ----------------------------------------------------------------------------
// Structure line classifier testbench
// Sends text lines one character per beat and checks each class code against
// a line model kept in step with every accepted beat. Directed lines cover each
// line kind, the tree rules, truncation, quit beats and deep nesting. Random
// lines follow, under random idling, a long receiver hold-off and mode changes.
// ----------------------------------------------------------------------------
module tb_structure_line_classifier;
   import slc_pkg::*;

   localparam int DEPTH_LIMIT  = 1023;
   localparam int NEST_DEPTH   = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int ALPHA_FULL   = 0;
   localparam int ALPHA_SHAP   = 1;
   localparam int ALPHA_COARSE = 2;

   logic clock;
   logic reset;

   slc_req_if req_bus ();
   slc_rsp_if rsp_bus ();
   slc_csr_if csr_bus ();

   structure_line_classifier #(.MAX_DEPTH(DEPTH_LIMIT)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Line model state.
   logic       mode_q;
   logic       list_open_q;
   logic       at_start_q;
   logic [2:0] lead_q;
   logic       cut_q;
   logic [2:0] guess_q;
   logic       saw_label_q;
   logic [10:0] bdepth_q;
   logic       bgood_q;
   logic [10:0] tdepth_q;
   logic [1:0] tphase_q;
   logic [2:0] tgood_q;
   char_type   prev1_q;
   char_type   prev2_q;

   class_type  class_due[$];
   char_type   line_buf[$];
   int         mismatch_count = 0;
   int         beat_count = 0;
   logic       idle_on = 1'b1;
   logic       hold_req = 1'b0;
   logic       pred_due;
   class_type  pred_cls;
   class_type  want_cls;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic clear_line();
      lead_q      = LEAD_OTHER;
      cut_q       = 1'b0;
      guess_q     = KIND_NONE;
      saw_label_q = 1'b0;
      bdepth_q    = '0;
      bgood_q     = 1'b1;
      tdepth_q    = '0;
      tphase_q    = PH_ITEM;
      tgood_q     = 3'b111;
      prev1_q     = CH_NUL;
      prev2_q     = CH_NUL;
   endtask

   function automatic logic [2:0] alphabet_mask(input char_type c);
      logic [2:0] m;
      case (c)
         CH_U, CH_P:             m = 3'b001;
         CH_S, CH_E:             m = 3'b010;
         CH_H, CH_B, CH_I, CH_M: m = 3'b110;
         default:                m = 3'b000;
      endcase
      return m;
   endfunction

   task automatic feed_brackets(input char_type c);
      if (c == CH_OPEN) begin
         if (bdepth_q >= DEPTH_LIMIT) bgood_q = 1'b0;
         else bdepth_q = bdepth_q + 1'b1;
      end else if (c == CH_CLOSE) begin
         if (bdepth_q == 0) bgood_q = 1'b0;
         else bdepth_q = bdepth_q - 1'b1;
      end else if (c != CH_DOT) begin
         bgood_q = 1'b0;
      end
   endtask

   task automatic close_node();
      if (tdepth_q == 0) tgood_q = 3'b000;
      else tdepth_q = tdepth_q - 1'b1;
      tphase_q = PH_CLOSE;
   endtask

   task automatic feed_tree(input char_type c);
      logic [2:0] m;
      m = alphabet_mask(c);
      if (tphase_q == PH_CLOSE && prev2_q == CH_R) begin
         tgood_q = 3'b000;
      end else if (tphase_q == PH_LABEL) begin
         if (!(c >= CH_ZERO && c <= CH_NINE)) begin
            if (c == CH_CLOSE) close_node();
            else tgood_q = 3'b000;
         end
      end else if (tphase_q == PH_ROOT) begin
         if (c == CH_CLOSE) close_node();
         else tgood_q = 3'b000;
      end else if (c == CH_OPEN) begin
         if (tdepth_q >= DEPTH_LIMIT) tgood_q = 3'b000;
         else tdepth_q = tdepth_q + 1'b1;
         tphase_q = PH_ITEM;
      end else if (m != 3'b000) begin
         tgood_q  = tgood_q & m;
         tphase_q = PH_LABEL;
      end else if (c == CH_R) begin
         tphase_q = PH_ROOT;
      end else if (c == CH_CLOSE && tphase_q == PH_ITEM) begin
         close_node();
      end else begin
         tgood_q = 3'b000;
      end
   endtask

   task automatic feed_guess(input char_type c);
      if (guess_q == KIND_NONE) begin
         if (c == CH_DOT) begin
            guess_q = KIND_DOT;
         end else if (c == CH_U || c == CH_P) begin
            guess_q     = KIND_FULL;
            saw_label_q = 1'b1;
         end else if (c == CH_S) begin
            guess_q     = KIND_SHAP;
            saw_label_q = 1'b1;
         end else if (c != CH_OPEN && c != CH_CLOSE) begin
            saw_label_q = 1'b1;
         end
      end
   endtask

   function automatic logic tree_valid(input int alpha);
      return tgood_q[alpha] && tphase_q == PH_CLOSE && tdepth_q == 0;
   endfunction

   task automatic judge_line(output class_type cls);
      logic       balanced;
      logic       rooted;
      logic [2:0] kind;
      balanced = bgood_q && bdepth_q == 0;
      rooted   = prev2_q == CH_R;
      cls      = CLS_SKIP;
      case (lead_q)
         LEAD_DOT: cls = balanced ? CLS_DOT : CLS_SKIP;
         LEAD_OPEN: begin
            if (guess_q != KIND_NONE) kind = guess_q;
            else kind = saw_label_q ? KIND_COARSE : KIND_DOT;
            case (kind)
               KIND_DOT: cls = balanced ? CLS_DOT : CLS_SKIP;
               KIND_FULL: begin
                  if (tree_valid(ALPHA_FULL)) cls = rooted ? CLS_FULL_ROOT : CLS_FULL_FREE;
               end
               KIND_SHAP: begin
                  if (tree_valid(ALPHA_SHAP)) cls = rooted ? CLS_SHAP_ROOT : CLS_SHAP_FREE;
               end
               default: begin
                  if (tree_valid(ALPHA_COARSE)) begin
                     cls = rooted ? CLS_COARSE_ROOT : CLS_COARSE_FREE;
                  end
               end
            endcase
         end
         LEAD_STAR: begin
            if (!list_open_q) begin
               if (mode_q) list_open_q = 1'b1;
               cls = CLS_SKIP;
            end else begin
               cls = CLS_LIST_BREAK;
            end
         end
         LEAD_AT: cls = CLS_QUIT;
         default: cls = CLS_SKIP;
      endcase
   endtask

   task automatic classify_char(input char_type c, input logic last, input logic done,
                                output logic due, output class_type cls);
      logic first;
      first = 1'b0;
      due   = 1'b0;
      cls   = CLS_SKIP;
      if (done) begin
         clear_line();
         at_start_q = 1'b1;
         due        = 1'b1;
         cls        = CLS_QUIT;
      end else begin
         if (at_start_q) begin
            clear_line();
            at_start_q = 1'b0;
            first      = 1'b1;
            case (c)
               CH_DOT:  lead_q = LEAD_DOT;
               CH_OPEN: lead_q = LEAD_OPEN;
               CH_STAR: lead_q = LEAD_STAR;
               CH_GT:   lead_q = LEAD_GT;
               CH_AT:   lead_q = LEAD_AT;
               default: lead_q = LEAD_OTHER;
            endcase
         end
         if (!cut_q && (lead_q == LEAD_DOT || lead_q == LEAD_OPEN)) begin
            if (c == CH_SPACE || c == CH_NUL) begin
               cut_q = 1'b1;
            end else begin
               feed_brackets(c);
               feed_tree(c);
               if (!first) feed_guess(c);
               prev2_q = prev1_q;
               prev1_q = c;
            end
         end
         if (last) begin
            judge_line(cls);
            at_start_q = 1'b1;
            due        = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q      = 1'b0;
         list_open_q = 1'b0;
         at_start_q  = 1'b1;
         clear_line();
         class_due.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (class_due.size() == 0) begin
               report_mismatch($sformatf("unexpected class code %0d", rsp_bus.line_class));
            end else begin
               want_cls = class_due.pop_front();
               if (rsp_bus.line_class !== want_cls) begin
                  report_mismatch($sformatf("line_class %0d, want %0d",
                                            rsp_bus.line_class, want_cls));
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) mode_q = csr_bus.matrix_mode;
         if (req_bus.valid && req_bus.ready) begin
            classify_char(req_bus.char_code, req_bus.line_end, req_bus.input_done,
                          pred_due, pred_cls);
            if (pred_due) class_due.push_back(pred_cls);
         end
      end
   end

   // The receiver stalls at random, or holds off for a long stretch on request.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < 8);
         end
      end
   end

   task automatic send_beat(input char_type c, input logic last, input logic done);
      int gap;
      if (idle_on && $urandom_range(99) < 8) begin
         gap = $urandom_range(3, 1);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.char_code  <= c;
      req_bus.line_end   <= last;
      req_bus.input_done <= done;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      beat_count++;
   endtask

   task automatic send_quit();
      send_beat(char_type'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
   endtask

   task automatic send_buf(input logic close_line);
      foreach (line_buf[i]) begin
         send_beat(line_buf[i], close_line && i == line_buf.size() - 1, 1'b0);
      end
   endtask

   task automatic fill_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      fill_text(s);
      send_buf(1'b1);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (class_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      foreach (class_due[i]) begin
         report_mismatch($sformatf("class code %0d never arrived", class_due[i]));
      end
      class_due.delete();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain();
      csr_bus.valid       <= 1'b1;
      csr_bus.matrix_mode <= m;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic char_type pick_label(input int alpha);
      char_type c;
      if (alpha == ALPHA_FULL) begin
         c = $urandom_range(1) ? CH_U : CH_P;
      end else begin
         case ($urandom_range(alpha == ALPHA_SHAP ? 5 : 3))
            0:       c = CH_H;
            1:       c = CH_B;
            2:       c = CH_I;
            3:       c = CH_M;
            4:       c = CH_S;
            default: c = CH_E;
         endcase
      end
      return c;
   endfunction

   task automatic build_tree();
      int   alpha;
      int   depth;
      int   digits;
      logic rooted;
      logic fresh;
      alpha  = $urandom_range(ALPHA_COARSE);
      rooted = 1'($urandom_range(1));
      line_buf.push_back(CH_OPEN);
      depth = 1;
      fresh = 1'b1;
      while (depth > 0) begin
         if (depth < 5 && line_buf.size() < 40 && $urandom_range(99) < 45) begin
            line_buf.push_back(CH_OPEN);
            depth++;
            fresh = 1'b1;
         end else begin
            if (depth == 1 && rooted) begin
               line_buf.push_back(CH_R);
            end else if (fresh && $urandom_range(99) < 10) begin
               digits = 0;
            end else if ($urandom_range(99) < 2) begin
               line_buf.push_back(CH_R);
            end else begin
               line_buf.push_back(pick_label(alpha));
               digits = $urandom_range(2);
               repeat (digits) line_buf.push_back(char_type'(CH_ZERO + $urandom_range(9)));
            end
            line_buf.push_back(CH_CLOSE);
            depth--;
            fresh = 1'b0;
         end
      end
   endtask

   task automatic build_dots();
      int depth;
      int steps;
      steps = $urandom_range(24, 1);
      if ($urandom_range(1)) begin
         line_buf.push_back(CH_DOT);
         depth = 0;
      end else begin
         line_buf.push_back(CH_OPEN);
         depth = 1;
      end
      repeat (steps) begin
         if (depth > 0 && $urandom_range(99) < 35) begin
            line_buf.push_back(CH_CLOSE);
            depth--;
         end else if ($urandom_range(99) < 45) begin
            line_buf.push_back(CH_OPEN);
            depth++;
         end else begin
            line_buf.push_back(CH_DOT);
         end
      end
      repeat (depth) line_buf.push_back(CH_CLOSE);
   endtask

   task automatic build_random_line();
      int    r;
      int    n;
      int    pos;
      string pool;
      pool = "().RUPHBIMSE09 *@>";
      line_buf.delete();
      r = $urandom_range(99);
      if (r < 38) begin
         build_tree();
      end else if (r < 62) begin
         build_dots();
      end else begin
         if (r < 70) line_buf.push_back(CH_STAR);
         else if (r < 75) line_buf.push_back(CH_GT);
         else if (r < 80) line_buf.push_back(CH_AT);
         else if (r < 85) line_buf.push_back(CH_SPACE);
         else line_buf.push_back(char_type'($urandom_range(255)));
         n = $urandom_range(6);
         repeat (n) line_buf.push_back(char_type'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 12) begin
         pos = $urandom_range(line_buf.size() - 1);
         if ($urandom_range(1)) line_buf[pos] = char_type'($urandom_range(255));
         else line_buf[pos] = pool[$urandom_range(pool.len() - 1)];
      end else if (r < 20) begin
         line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_NUL);
         n = $urandom_range(4);
         repeat (n) line_buf.push_back(pool[$urandom_range(pool.len() - 1)]);
      end else if (r < 25 && line_buf.size() > 1) begin
         void'(line_buf.pop_back());
      end
   endtask

   task automatic send_nest(input int n, input logic as_tree, input logic rooted);
      line_buf.delete();
      repeat (n) line_buf.push_back(CH_OPEN);
      for (int i = 0; i < n; i++) begin
         if (as_tree) line_buf.push_back((rooted && i == n - 1) ? CH_R : CH_U);
         line_buf.push_back(CH_CLOSE);
      end
      send_buf(1'b1);
   endtask

   task automatic test_line_kinds();
      send_text(".((..)).");
      send_text("..(");
      send_text("(..)");
      send_text("()");
      send_text("(");
      send_text(">((..))");
      send_text("@");
      send_text("@xyz");
      send_text("*");
      send_text("* list");
      send_text(" ((..))");
      send_text("hello");
      line_buf = '{CH_DOT, 8'hFF, CH_DOT, 8'h80};
      send_buf(1'b1);
   endtask

   task automatic test_tree_shapes();
      send_text("((U)(P)R)");
      send_text("((U12)(P3))");
      send_text("((H)(S)R)");
      send_text("((H)(E3)(S))");
      send_text("((H)(B)R)");
      send_text("((I1)(M))");
      send_text("(R)");
      send_text("((U)R)(U)");
      send_text("((U)(P");
      send_text("((U)R");
      send_text("((U)(");
      send_text("((U)(S))");
      send_text("((U))");
   endtask

   task automatic test_cut_and_quit();
      send_text("((..)) trailing");
      send_text("(( ..))");
      fill_text("((U)R)");
      line_buf.push_back(CH_NUL);
      line_buf.push_back(CH_CLOSE);
      send_buf(1'b1);
      fill_text("((U");
      send_buf(1'b0);
      send_quit();
      send_text("(..)");
      send_quit();
      send_beat(CH_DOT, 1'b1, 1'b1);
      send_text("((H)(I)R)");
   endtask

   task automatic test_deep_nesting();
      send_nest(NEST_DEPTH, 1'b0, 1'b0);
      send_nest(NEST_DEPTH, 1'b1, 1'b1);
   endtask

   task automatic test_list_mode();
      write_mode(1'b1);
      send_text("*");
      send_text("*abc");
      send_text("*");
      write_mode(1'b0);
      send_text("*");
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (40) begin
         case ($urandom_range(3))
            0:       send_text("@");
            1:       send_text(".");
            2:       send_text("*");
            default: send_text("(.)");
         endcase
      end
      drain();
   endtask

   task automatic test_random_lines(input int beats);
      int start;
      int r;
      int keep;
      start = beat_count;
      while (beat_count - start < beats) begin
         r = $urandom_range(99);
         if (r < 3) begin
            send_quit();
         end else begin
            build_random_line();
            if (r < 8 && line_buf.size() > 1) begin
               keep = $urandom_range(line_buf.size() - 1, 1);
               while (line_buf.size() > keep) void'(line_buf.pop_back());
               send_buf(1'b0);
               send_quit();
            end else begin
               send_buf(1'b1);
            end
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.char_code    <= '0;
      req_bus.line_end     <= 1'b0;
      req_bus.input_done   <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.matrix_mode  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b0);
      test_line_kinds();
      test_tree_shapes();
      test_cut_and_quit();
      test_deep_nesting();
      test_random_lines(200);
      test_list_mode();
      test_backpressure();
      write_mode(1'b1);
      test_random_lines(200);
      idle_on = 1'b0;
      test_random_lines(150);
      idle_on = 1'b1;
      write_mode(1'b0);
      test_random_lines(200);
      drain();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
